[sv/frsr_pkg.sv]
// shared types and constants for the sequence recovery core
package frsr_pkg;

    localparam int NUM_STREAMS_DEF = 16;
    localparam int WINDOW_DEF      = 64;

    localparam int IDX_W     = 4;
    localparam int SEQ_W     = 16;
    localparam int VERDICT_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT  = 2'd0,
        VERDICT_DUP     = 2'd1,
        VERDICT_OVERRUN = 2'd2,
        VERDICT_RESET   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic load_res;
        logic commit;
    } frsr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } frsr_status_t;

endpackage

[sv/frsr_ram.sv]
// generic single write port ram with registered read
module frsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/frsr_ctrl.sv]
// controller state machine for the sequence recovery core
module frsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  frsr_pkg::frsr_status_t status,
    output frsr_pkg::frsr_cmd_t    cmd
);
    import frsr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.load_res = 1'b1;
                state_next   = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/frsr_dp.sv]
// datapath: stream table, window position, verdict and output register
module frsr_dp #(
    parameter int NUM_STREAMS = frsr_pkg::NUM_STREAMS_DEF,
    parameter int WINDOW      = frsr_pkg::WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frsr_pkg::frsr_cmd_t            cmd,
    output frsr_pkg::frsr_status_t         status,
    input  logic                           in_mode,
    input  logic [frsr_pkg::IDX_W-1:0]     in_idx,
    input  logic [frsr_pkg::SEQ_W-1:0]     in_seq,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [frsr_pkg::VERDICT_W-1:0] out_verdict,
    output logic [frsr_pkg::IDX_W-1:0]     out_echo
);
    import frsr_pkg::*;

    localparam int AW         = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int PW         = $clog2(WINDOW);
    localparam int DW         = 1 + SEQ_W + WINDOW;
    localparam int RecipShift = SEQ_W + 6;
    localparam int ProdW      = SEQ_W + RecipShift;
    localparam logic [RecipShift-1:0] RecipMul =
        RecipShift'(((2 ** RecipShift) + WINDOW - 1) / WINDOW);

    logic                   mode_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic [SEQ_W-1:0]       quot_reg;
    logic [PW-1:0]          pos_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   out_valid_reg;
    verdict_t               verdict_reg;
    logic [IDX_W-1:0]       echo_reg;

    logic [ProdW-1:0]       prod;
    logic [SEQ_W-1:0]       pos_full;
    logic [DW-1:0]          rd_data;
    logic [DW-1:0]          wr_data;
    logic [AW-1:0]          wr_addr;
    logic                   wr_en;
    logic                   upd;
    verdict_t               verdict;
    logic                   in_range;
    logic                   old_active;
    logic [SEQ_W-1:0]       old_hi;
    logic [WINDOW-1:0]      old_map;
    logic [SEQ_W-1:0]       udiff;
    logic [SEQ_W-1:0]       lag;
    logic [WINDOW-1:0]      seq_bit;
    logic [WINDOW-1:0]      clr_mask;
    logic [PW:0]            pos_gap;

    assign prod     = ProdW'(in_seq) * ProdW'(RecipMul);
    assign pos_full = seq_reg - SEQ_W'(quot_reg * SEQ_W'(WINDOW));

    assign old_active = rd_data[DW-1];
    assign old_hi     = rd_data[DW-2 -: SEQ_W];
    assign old_map    = rd_data[WINDOW-1:0];
    assign udiff      = seq_reg - old_hi;
    assign lag        = old_hi - seq_reg;
    assign seq_bit    = WINDOW'(1) << pos_reg;
    assign in_range   = {{(32-IDX_W){1'b0}}, idx_reg} < 32'(NUM_STREAMS);

    always_comb
    begin
        pos_gap  = '0;
        clr_mask = '0;
        for (int p = 0; p < WINDOW; p++)
        begin
            if ({1'b0, pos_reg} >= (PW+1)'(p))
            begin
                pos_gap = {1'b0, pos_reg} - (PW+1)'(p);
            end
            else
            begin
                pos_gap = {1'b0, pos_reg} + (PW+1)'(WINDOW) - (PW+1)'(p);
            end
            clr_mask[p] = SEQ_W'(pos_gap) < udiff;
        end
    end

    always_comb
    begin
        verdict = VERDICT_DUP;
        upd     = 1'b0;
        wr_data = {1'b1, seq_reg, seq_bit};
        if (mode_reg)
        begin
            verdict = VERDICT_RESET;
            upd     = in_range;
            wr_data = {1'b0, old_hi, {WINDOW{1'b0}}};
        end
        else if (!in_range)
        begin
            verdict = VERDICT_DUP;
        end
        else if (!old_active)
        begin
            verdict = VERDICT_ACCEPT;
            upd     = 1'b1;
        end
        else if (udiff == '0)
        begin
            verdict = VERDICT_DUP;
        end
        else if (!udiff[SEQ_W-1])
        begin
            verdict = VERDICT_ACCEPT;
            upd     = 1'b1;
            if (udiff < SEQ_W'(WINDOW))
            begin
                wr_data = {1'b1, seq_reg, (old_map & ~clr_mask) | seq_bit};
            end
        end
        else if (lag >= SEQ_W'(WINDOW))
        begin
            verdict = VERDICT_OVERRUN;
        end
        else if ((old_map & seq_bit) == '0)
        begin
            verdict = VERDICT_ACCEPT;
            upd     = 1'b1;
            wr_data = {1'b1, old_hi, old_map | seq_bit};
        end
        else
        begin
            verdict = VERDICT_DUP;
        end
        if (cmd.clear_step)
        begin
            wr_data = '0;
        end
    end

    assign wr_en   = cmd.clear_step | (cmd.commit & upd);
    assign wr_addr = cmd.clear_step ? clr_addr_reg : AW'(idx_reg);

    frsr_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_STREAMS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.load_in),
        .rd_addr (AW'(in_idx)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= in_mode;
            idx_reg  <= in_idx;
            seq_reg  <= in_seq;
            quot_reg <= prod[ProdW-1 -: SEQ_W];
        end
        if (cmd.load_res)
        begin
            pos_reg <= pos_full[PW-1:0];
        end
        if (cmd.commit)
        begin
            verdict_reg <= verdict;
            echo_reg    <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = clr_addr_reg == AW'(NUM_STREAMS - 1);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_verdict       = verdict_reg;
    assign out_echo          = echo_reg;

endmodule

[sv/frer_sequence_recovery_core.sv]
// top level of the frame replication and elimination sequence recovery core
//
// Per-stream duplicate elimination: each input beat either checks one packet
// (stream index and 16-bit sequence number) against the stream's highest seen
// number and a WINDOW-position history bitmap, or resets that stream; each
// beat yields exactly one verdict beat (accept, duplicate, window overrun,
// reset done) with the stream index echoed. An item passes in order through
// accept and table read, window position, and verdict and table write: the
// stream table has a registered read, and the window position step sits
// between the quotient and the verdict; a verdict waiting in the output
// register only delays the write step, and the core takes no new beat until
// the verdict is written. After reset the core clears every entry of the
// stream table before it takes its first beat.
module frer_sequence_recovery_core #(
    parameter int NUM_STREAMS = frsr_pkg::NUM_STREAMS_DEF,
    parameter int WINDOW      = frsr_pkg::WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [frsr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // stream_index, seq_num
    input  logic                           s_axis_tuser,  // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [frsr_pkg::M_TDATA_W-1:0] m_axis_tdata   // verdict, stream_echo
);
    import frsr_pkg::*;

    frsr_cmd_t             cmd;
    frsr_status_t          status;
    logic [VERDICT_W-1:0]  verdict;
    logic [IDX_W-1:0]      echo;

    frsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frsr_dp #(
        .NUM_STREAMS (NUM_STREAMS),
        .WINDOW      (WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_mode     (s_axis_tuser),
        .in_idx      (s_axis_tdata[IDX_W-1:0]),
        .in_seq      (s_axis_tdata[IDX_W +: SEQ_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict),
        .out_echo    (echo)
    );

    assign m_axis_tdata = {{(M_TDATA_W - VERDICT_W - IDX_W){1'b0}}, echo, verdict};

endmodule

[sv/frsr_checker.sv]
// port-level checker for the sequence recovery core, with its bind
module frsr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [frsr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import frsr_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pending_reg != 2'd0)
        else $error("verdict beat without a pending item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many items in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled verdict beat changed");

endmodule

bind frer_sequence_recovery_core frsr_checker u_frsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/frer_sequence_recovery_core_test.sv]
// testbench for the frame replication and elimination sequence recovery core
`timescale 1ns / 100ps

module frer_sequence_recovery_core_test;

    import frsr_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        verdict_t   verdict;
        logic [3:0] stream;
    } verdict_due_t;

    class dedup_tracker;
        bit           active [NUM_STREAMS_DEF];
        bit [15:0]    top_seq [NUM_STREAMS_DEF];
        bit [63:0]    seen_bits [NUM_STREAMS_DEF];
        verdict_due_t verdicts_due [$];
        int           errors;

        function new();
            foreach (active[i])
            begin
                active[i]    = 1'b0;
                top_seq[i]   = '0;
                seen_bits[i] = '0;
            end
            errors = 0;
        endfunction

        function bit [63:0] slot_mask(int unsigned seq);
            return 64'd1 << ((seq % WINDOW_DEF) & 63);
        endfunction

        function verdict_t judge_packet(int unsigned s, bit [15:0] seq);
            bit [15:0]   gap;
            int unsigned lag;
            if (!active[s])
            begin
                active[s]    = 1'b1;
                top_seq[s]   = seq;
                seen_bits[s] = slot_mask(seq);
                return VERDICT_ACCEPT;
            end
            gap = seq - top_seq[s];
            if (gap == 16'd0)
                return VERDICT_DUP;
            if (gap < 16'h8000)
            begin
                if (gap >= WINDOW_DEF)
                    seen_bits[s] = '0;
                else
                    for (int unsigned i = 1; i <= gap; i++)
                        seen_bits[s] &= ~slot_mask(int'(top_seq[s]) + i);
                top_seq[s]   = seq;
                seen_bits[s] |= slot_mask(seq);
                return VERDICT_ACCEPT;
            end
            lag = 65536 - gap;
            if (lag >= WINDOW_DEF)
                return VERDICT_OVERRUN;
            if ((seen_bits[s] & slot_mask(seq)) == '0)
            begin
                seen_bits[s] |= slot_mask(seq);
                return VERDICT_ACCEPT;
            end
            return VERDICT_DUP;
        endfunction

        function void note_beat(bit mode, bit [3:0] idx, bit [15:0] seq);
            verdict_due_t due;
            due.stream = idx;
            if (mode)
            begin
                if (idx < NUM_STREAMS_DEF)
                begin
                    active[idx]    = 1'b0;
                    seen_bits[idx] = '0;
                end
                due.verdict = VERDICT_RESET;
            end
            else if (idx < NUM_STREAMS_DEF)
                due.verdict = judge_packet(idx, seq);
            else
                due.verdict = VERDICT_DUP;
            verdicts_due.push_back(due);
        endfunction

        function void check_verdict(logic [1:0] verdict, logic [3:0] stream);
            verdict_due_t due;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict beat %0d stream %0d",
                         $time, verdict, stream);
                errors++;
                return;
            end
            due = verdicts_due.pop_front();
            if (verdict !== due.verdict)
            begin
                $display("%0t: verdict mismatch expected %0d actual %0d",
                         $time, due.verdict, verdict);
                errors++;
            end
            if (stream !== due.stream)
            begin
                $display("%0t: stream_echo mismatch expected %0d actual %0d",
                         $time, due.stream, stream);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // stream_index, seq_num
    logic                 s_axis_tuser = 1'b0; // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // verdict, stream_echo

    dedup_tracker tracker = new();
    int           idle_pct = 0;
    int           stall_pct = 0;
    bit           hold_pending = 1'b0;
    int           cycles = 0;
    bit [15:0]    lead_seq [16];

    frer_sequence_recovery_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_verdict(m_axis_tdata[1:0], m_axis_tdata[5:2]);

    task automatic send_item(bit mode, bit [3:0] idx, bit [15:0] seq);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, seq, idx};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_beat(mode, idx, seq);
    endtask

    task automatic send_random_item();
        int        pick;
        bit [3:0]  idx;
        bit [15:0] seq;
        pick = $urandom_range(0, 99);
        idx  = 4'($urandom_range(0, 15));
        seq  = 16'($urandom);
        if (pick < 4)
            send_item(1'b1, idx, seq);
        else if (pick < 9)
        begin
            lead_seq[idx] = seq;
            send_item(1'b0, idx, seq);
        end
        else
        begin
            // walk forward and land near the top of the window
            if ($urandom_range(0, 1))
                lead_seq[idx] += 16'($urandom_range(1, 6));
            seq = lead_seq[idx] - 16'($urandom_range(0, 70));
            send_item(1'b0, idx, seq);
        end
    endtask

    initial
    begin
        foreach (lead_seq[i])
            lead_seq[i] = 16'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_item(1'b0, 4'd0, 16'd0);
        send_item(1'b0, 4'd0, 16'd0);
        send_item(1'b0, 4'd0, 16'd1);
        send_item(1'b0, 4'd0, 16'd65535);
        send_item(1'b0, 4'd0, 16'd65535);
        send_item(1'b0, 4'd0, 16'd32769);
        send_item(1'b0, 4'd0, 16'd32768);
        send_item(1'b0, 4'd0, 16'd32705);
        send_item(1'b0, 4'd0, 16'd32704);
        send_item(1'b0, 4'd0, 16'd32832);
        send_item(1'b0, 4'd0, 16'd32895);
        send_item(1'b0, 4'd0, 16'd32832);
        send_item(1'b1, 4'd15, 16'hFFFF);
        send_item(1'b1, 4'd0, 16'd0);
        send_item(1'b0, 4'd0, 16'hABCD);
        send_item(1'b0, 4'd15, 16'd65535);
        send_item(1'b0, 4'd15, 16'd65533);
        send_item(1'b0, 4'd15, 16'd4);
        send_item(1'b0, 4'd15, 16'd65533);
        send_item(1'b0, 4'd10, 16'h5555);
        send_item(1'b0, 4'd10, 16'h2AAA);
        send_item(1'b0, 4'd10, 16'hD555);
        send_item(1'b0, 4'd5, 16'h8000);
        send_item(1'b1, 4'd10, 16'h1234);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase
            repeat (125) send_random_item();
        end

        // long receiver hold-off so the core backs up
        idle_pct     = 0;
        stall_pct    = 0;
        hold_pending = 1'b1;
        repeat (40) send_random_item();
        s_axis_tvalid <= 1'b0;

        while (tracker.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
